// ===== src/hpd_pkg.sv =====
// Shared types and constants of the header/payload message deframer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package hpd_pkg;

	// Bytes that the parser looks for.
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// The header name that carries the payload size: "Length: ".
	localparam logic [3:0] PREFIX_LEN = 4'd8;
	localparam logic [7:0] LEN_PREFIX [0:7] = '{
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	// Width of the reported payload size.
	localparam int OUT_LEN_BITS = 32;

	typedef enum logic [2:0] {
		KIND_HDR_BYTE = 3'd0,
		KIND_LINE_END = 3'd1,
		KIND_HDRS_END = 3'd2,
		KIND_PAYLOAD  = 3'd3,
		KIND_ERROR    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADERS = 2'b01,
		PH_PAYLOAD = 2'b10
	} phase_t;

	typedef enum logic [2:0] {
		COLON_NONE  = 3'b001,
		COLON_SEEN  = 3'b010,
		COLON_SPACE = 3'b100
	} colon_t;

	// Restriction on the next continuation byte of a UTF-8 sequence.
	typedef enum logic [2:0] {
		UC_NONE  = 3'd0,
		UC_AF_E0 = 3'd1,
		UC_AF_ED = 3'd2,
		UC_AF_F0 = 3'd3,
		UC_AF_F4 = 3'd4
	} utf_con_t;

	typedef struct packed {
		logic [7:0]              data;
		kind_t                   kind;
		logic                    done;
		logic [OUT_LEN_BITS-1:0] length;
		logic                    malformed;
	} hpd_result_t;

endpackage

`default_nettype wire

// ===== src/header_payload_message_deframer_core.sv =====
// Top level of the header/payload message deframer: parser plus output buffer.
// Depends on hpd_pkg and hpd_parse.
//
// The block takes one stream byte per request and returns one tagged result per byte,
// in order: header byte, header line end, end of headers (with the payload size),
// payload byte, or error. A byte is accepted in every cycle while the output side
// keeps up; its result appears in the output register on the following cycle, so the
// sustained rate is one byte per clock. The rate is set by the update of the parser
// state, which each byte reads and rewrites. A two-entry output buffer (result register
// plus skid register) lets one further byte be taken after the output side has started
// to stall; byte_stall then rises and stays high until the skid entry has moved on. Once
// a malformed header has been seen the block stays in its error state until reset,
// tagging every byte as an error. Sizes above the 32-bit port are masked there, while
// the internal counter keeps LENGTH_BITS bits.
`default_nettype none

module header_payload_message_deframer_core #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       kind,
	output logic             message_done,
	output logic [31:0]      payload_length,
	output logic             malformed
);

	hpd_pkg::hpd_result_t res;
	hpd_pkg::hpd_result_t main_q, skid_q;
	logic                 main_valid_q, skid_valid_q;
	logic                 take_in, take_out;

	// The input side stalls only while the skid entry is occupied.
	assign byte_stall = skid_valid_q;
	assign take_in    = byte_valid && !skid_valid_q;
	assign take_out   = main_valid_q && !result_stall;

	hpd_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take_in),
		.data_byte(data_byte),
		.result   (res)
	);

	// Occupancy of the result and skid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take_out)
				skid_valid_q <= 1'b0;
		end else if (take_in) begin
			main_valid_q <= 1'b1;
			if (main_valid_q && !take_out)
				skid_valid_q <= 1'b1;
		end else if (take_out) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload of the buffer; the skid entry drains into the result register first,
	// which keeps the order of results.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take_out)
				main_q <= skid_q;
		end else if (take_in) begin
			if (!main_valid_q || take_out)
				main_q <= res;
			else
				skid_q <= res;
		end
	end

	assign result_valid   = main_valid_q;
	assign out_byte       = main_q.data;
	assign kind           = main_q.kind;
	assign message_done   = main_q.done;
	assign payload_length = main_q.length;
	assign malformed      = main_q.malformed;

endmodule

`default_nettype wire

// ===== src/hpd_parse.sv =====
// Per-byte parser state and the combinational result of the current byte.
// Depends on hpd_pkg for codes, the prefix table and the result struct.
`default_nettype none

module hpd_parse #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         data_byte,
	output hpd_pkg::hpd_result_t    result
);

	localparam int AW = LENGTH_BITS + 4;

	hpd_pkg::phase_t          phase_q,     phase_n;
	logic                     line_start_q, line_start_n;
	hpd_pkg::colon_t          colon_q,     colon_n;
	logic                     line_bad_q,  line_bad_n;
	logic [3:0]               prefix_pos_q, prefix_pos_n;
	logic                     prefix_alive_q, prefix_alive_n;
	logic                     len_found_q, len_found_n;
	logic [LENGTH_BITS-1:0]   accum_q,     accum_n;
	logic [1:0]               utf_pend_q,  utf_pend_n;
	hpd_pkg::utf_con_t        utf_con_q,   utf_con_n;
	logic [LENGTH_BITS-1:0]   remain_q,    remain_n;
	logic                     dead_q,      dead_n;

	logic                     utf_ok;
	logic [1:0]               utf_pend_t;
	hpd_pkg::utf_con_t        utf_con_t2;
	logic [7:0]               lo, hi;

	logic [AW-1:0]            acc_ext, acc_mac;
	logic [3:0]               digit;
	logic                     is_digit;
	logic [LENGTH_BITS-1:0]   remain_dec;
	logic [LENGTH_BITS-1:0]   plen;
	logic [LENGTH_BITS+31:0]  plen_wide;
	logic                     new_line, new_msg;
	hpd_pkg::kind_t           kind;
	logic                     done;

	// UTF-8 sequence checker for one byte.
	always_comb begin
		utf_ok     = 1'b1;
		utf_pend_t = utf_pend_q;
		utf_con_t2 = utf_con_q;
		lo         = 8'h80;
		hi         = 8'hBF;
		if (utf_pend_q == 2'd0) begin
			priority if (data_byte < 8'h80) begin
				utf_ok = 1'b1;
			end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
				utf_pend_t = 2'd1;
				utf_con_t2 = hpd_pkg::UC_NONE;
			end else if (data_byte == 8'hE0) begin
				utf_pend_t = 2'd2;
				utf_con_t2 = hpd_pkg::UC_AF_E0;
			end else if (data_byte == 8'hED) begin
				utf_pend_t = 2'd2;
				utf_con_t2 = hpd_pkg::UC_AF_ED;
			end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
				utf_pend_t = 2'd2;
				utf_con_t2 = hpd_pkg::UC_NONE;
			end else if (data_byte == 8'hF0) begin
				utf_pend_t = 2'd3;
				utf_con_t2 = hpd_pkg::UC_AF_F0;
			end else if (data_byte == 8'hF4) begin
				utf_pend_t = 2'd3;
				utf_con_t2 = hpd_pkg::UC_AF_F4;
			end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
				utf_pend_t = 2'd3;
				utf_con_t2 = hpd_pkg::UC_NONE;
			end else begin
				utf_ok = 1'b0;
			end
		end else begin
			unique case (utf_con_q)
				hpd_pkg::UC_AF_E0: lo = 8'hA0;
				hpd_pkg::UC_AF_ED: hi = 8'h9F;
				hpd_pkg::UC_AF_F0: lo = 8'h90;
				hpd_pkg::UC_AF_F4: hi = 8'h8F;
				default: ;
			endcase
			utf_con_t2 = hpd_pkg::UC_NONE;
			if (data_byte < lo || data_byte > hi) begin
				utf_ok     = 1'b0;
				utf_pend_t = 2'd0;
			end else begin
				utf_pend_t = utf_pend_q - 2'd1;
			end
		end
	end

	// Decimal accumulate with saturation: accum * 10 + digit, clamped.
	assign digit    = 4'(data_byte - hpd_pkg::CH_ZERO);
	assign is_digit = (data_byte >= hpd_pkg::CH_ZERO) && (data_byte <= hpd_pkg::CH_NINE);
	assign acc_ext  = {4'b0, accum_q};
	assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + {{(AW-4){1'b0}}, digit};

	assign remain_dec = (remain_q != '0) ? remain_q - LENGTH_BITS'(1) : remain_q;
	assign plen       = len_found_q ? accum_q : '0;

	always_comb begin
		phase_n        = phase_q;
		line_start_n   = line_start_q;
		colon_n        = colon_q;
		line_bad_n     = line_bad_q;
		prefix_pos_n   = prefix_pos_q;
		prefix_alive_n = prefix_alive_q;
		len_found_n    = len_found_q;
		accum_n        = accum_q;
		utf_pend_n     = utf_pend_q;
		utf_con_n      = utf_con_q;
		remain_n       = remain_q;
		dead_n         = dead_q;
		new_line       = 1'b0;
		new_msg        = 1'b0;
		kind           = hpd_pkg::KIND_ERROR;
		done           = 1'b0;
		plen_wide      = '0;

		if (dead_q) begin
			kind = hpd_pkg::KIND_ERROR;
		end else if (phase_q == hpd_pkg::PH_PAYLOAD) begin
			kind     = hpd_pkg::KIND_PAYLOAD;
			remain_n = remain_dec;
			if (remain_dec == '0) begin
				done    = 1'b1;
				new_msg = 1'b1;
			end
		end else if (data_byte == hpd_pkg::CH_LF) begin
			if (line_start_q) begin
				kind      = hpd_pkg::KIND_HDRS_END;
				plen_wide = {32'b0, plen};
				if (plen == '0) begin
					done    = 1'b1;
					new_msg = 1'b1;
				end else begin
					remain_n = plen;
					phase_n  = hpd_pkg::PH_PAYLOAD;
					new_line = 1'b1;
				end
			end else begin
				if (line_bad_q || colon_q != hpd_pkg::COLON_SPACE || utf_pend_q != 2'd0) begin
					kind   = hpd_pkg::KIND_ERROR;
					dead_n = 1'b1;
				end else begin
					kind = hpd_pkg::KIND_LINE_END;
					if (prefix_alive_q && prefix_pos_q == hpd_pkg::PREFIX_LEN && !len_found_q)
						len_found_n = 1'b1;
				end
				new_line = 1'b1;
			end
		end else begin
			kind         = hpd_pkg::KIND_HDR_BYTE;
			line_start_n = 1'b0;
			utf_pend_n   = utf_pend_t;
			utf_con_n    = utf_con_t2;
			if (data_byte == hpd_pkg::CH_NUL || !utf_ok)
				line_bad_n = 1'b1;
			unique case (colon_q)
				hpd_pkg::COLON_NONE: begin
					if (data_byte == hpd_pkg::CH_COLON)
						colon_n = hpd_pkg::COLON_SEEN;
				end
				hpd_pkg::COLON_SEEN: begin
					if (data_byte == hpd_pkg::CH_SPACE)
						colon_n = hpd_pkg::COLON_SPACE;
					else
						line_bad_n = 1'b1;
				end
				default: ;
			endcase
			if (prefix_alive_q) begin
				if (prefix_pos_q < hpd_pkg::PREFIX_LEN) begin
					if (data_byte == hpd_pkg::LEN_PREFIX[prefix_pos_q[2:0]])
						prefix_pos_n = prefix_pos_q + 4'd1;
					else
						prefix_alive_n = 1'b0;
				end else if (!len_found_q) begin
					if (is_digit) begin
						if (acc_mac[AW-1:LENGTH_BITS] != '0)
							accum_n = '1;
						else
							accum_n = acc_mac[LENGTH_BITS-1:0];
					end else begin
						line_bad_n = 1'b1;
					end
				end
			end
		end

		if (new_line || new_msg) begin
			line_start_n   = 1'b1;
			colon_n        = hpd_pkg::COLON_NONE;
			line_bad_n     = 1'b0;
			prefix_pos_n   = 4'd0;
			prefix_alive_n = 1'b1;
			utf_pend_n     = 2'd0;
			utf_con_n      = hpd_pkg::UC_NONE;
		end
		if (new_msg) begin
			phase_n     = hpd_pkg::PH_HEADERS;
			len_found_n = 1'b0;
			accum_n     = '0;
			remain_n    = '0;
		end
	end

	assign result.data      = data_byte;
	assign result.kind      = kind;
	assign result.done      = done;
	assign result.length    = plen_wide[hpd_pkg::OUT_LEN_BITS-1:0];
	assign result.malformed = dead_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= hpd_pkg::PH_HEADERS;
			line_start_q   <= 1'b1;
			colon_q        <= hpd_pkg::COLON_NONE;
			line_bad_q     <= 1'b0;
			prefix_pos_q   <= 4'd0;
			prefix_alive_q <= 1'b1;
			len_found_q    <= 1'b0;
			accum_q        <= '0;
			utf_pend_q     <= 2'd0;
			utf_con_q      <= hpd_pkg::UC_NONE;
			remain_q       <= '0;
			dead_q         <= 1'b0;
		end else if (take) begin
			phase_q        <= phase_n;
			line_start_q   <= line_start_n;
			colon_q        <= colon_n;
			line_bad_q     <= line_bad_n;
			prefix_pos_q   <= prefix_pos_n;
			prefix_alive_q <= prefix_alive_n;
			len_found_q    <= len_found_n;
			accum_q        <= accum_n;
			utf_pend_q     <= utf_pend_n;
			utf_con_q      <= utf_con_n;
			remain_q       <= remain_n;
			dead_q         <= dead_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/hpd_checker.sv =====
// Port-level checks on the deframer outputs, bound to the top level.
// Depends on hpd_pkg for the result codes.
`default_nettype none

module hpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [7:0]  out_byte,
	input wire logic [2:0]  kind,
	input wire logic        message_done,
	input wire logic [31:0] payload_length,
	input wire logic        malformed
);

	// Once malformed, every result is an error.
	a_malformed_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && malformed |-> kind == hpd_pkg::KIND_ERROR)
		else $error("malformed result not tagged as error");

	// A message ends only on a payload byte or on the blank line.
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && message_done |->
			kind == hpd_pkg::KIND_PAYLOAD || kind == hpd_pkg::KIND_HDRS_END)
		else $error("message done on an unexpected kind");

	// A completed message never coincides with the error state.
	a_done_not_dead: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && message_done |-> !malformed)
		else $error("message done while malformed");

	// The size is reported only at the end of the headers.
	a_length_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && payload_length != 32'd0 |-> kind == hpd_pkg::KIND_HDRS_END)
		else $error("payload length outside end of headers");

	// A stalled result holds.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) && $stable(kind))
		else $error("stalled result changed");

endmodule

bind header_payload_message_deframer_core hpd_checker u_hpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.out_byte      (out_byte),
	.kind          (kind),
	.message_done  (message_done),
	.payload_length(payload_length),
	.malformed     (malformed)
);

`default_nettype wire
